/* hw/rtl/source_text_tokenizer_defines.svh */
// Assertion macros for the tokenizer top level.
// Depends on nothing; the user supplies clk and rst in scope.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define STT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/stt_pkg.sv */
// Shared types, token codes and keyword table of the tokenizer.
// No dependencies.
package stt_pkg;

  localparam int KEYWORD_WINDOW  = 6;
  localparam int LINE_COUNT_BITS = 20;
  localparam int LINE_NUM_W      = 20;
  localparam int CHAR_W          = 8;
  localparam int TOKEN_W         = 5;
  localparam int LEN_W           = $clog2(KEYWORD_WINDOW + 2);
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [TOKEN_W-1:0] {
    TK_ID, TK_INTLITERAL, TK_MAIN, TK_READ, TK_WRITE, TK_IF, TK_ELSE, TK_WHILE,
    TK_PLUSOP, TK_MINUSOP, TK_ASSIGNOP, TK_LPAREN, TK_RPAREN, TK_MULTOP,
    TK_DIVOP, TK_COMMA, TK_SEMICOLON, TK_SCANEOF, TK_GREATER, TK_GREATEQ,
    TK_LESS, TK_LESSEQ, TK_EQUALS, TK_NOTEQ, TK_LCURL, TK_RCURL, TK_ERROR
  } token_t;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_SLASH, M_COMMENT,
    M_EQ, M_BANG, M_LT, M_GT, M_COLON
  } mode_t;

  localparam logic [CHAR_W-1:0] CH_NL         = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;

  localparam int KW_COUNT   = 6;
  localparam int KW_MAX_LEN = 5;

  // keyword text, left justified, zero padded
  localparam logic [KW_MAX_LEN*CHAR_W-1:0] KW_TEXT [KW_COUNT] = '{
    {"main", 8'h00}, {"if", 24'h0}, {"else", 8'h00},
    "while", {"read", 8'h00}, "write"
  };
  localparam int     KW_LEN  [KW_COUNT] = '{4, 2, 4, 5, 4, 5};
  localparam token_t KW_CODE [KW_COUNT] = '{TK_MAIN, TK_IF, TK_ELSE,
                                            TK_WHILE, TK_READ, TK_WRITE};

  // results of one input item, as queued between front and back
  typedef struct packed {
    logic                  two;
    token_t                kind0;
    token_t                kind1;
    logic [LINE_NUM_W-1:0] line;
  } result_pair_t;

endpackage

/* hw/rtl/stt_front.sv */
// Scanner front end: takes one byte per cycle unless q_full, keeps the lexer
// state and line count, and queues 0 to 2 results per item. Uses stt_pkg.
module stt_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [stt_pkg::CHAR_W-1:0]  char_byte,
  input  logic                        end_of_text,
  input  logic                        q_full,
  output logic                        q_push,
  output stt_pkg::result_pair_t       q_data
);
  import stt_pkg::*;

  mode_t                     mode, mode_next;
  logic [LEN_W-1:0]          len, len_next;
  logic [LINE_COUNT_BITS-1:0] line_count;
  logic [CHAR_W-1:0]         chars [KEYWORD_WINDOW];

  logic             acc;
  logic             e1_v, e2_v, done, app, bump;
  token_t           e1_k, e2_k, kw_kind;
  logic [LEN_W-1:0] app_pos;
  logic [CHAR_W-1:0] c;
  logic             is_alpha, is_digit, is_space;

  assign acc = push && !q_full;
  assign c   = char_byte;

  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit = c >= "0" && c <= "9";
  assign is_space = c == " " || (c >= 8'd9 && c <= 8'd13);

  // keyword lookup over the pending identifier
  always_comb begin
    logic hit;
    kw_kind = TK_ID;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      hit = (len == LEN_W'(KW_LEN[k])) && (KW_LEN[k] <= KEYWORD_WINDOW);
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if (j < KW_LEN[k] &&
            chars[j] != KW_TEXT[k][(KW_MAX_LEN-1-j)*CHAR_W +: CHAR_W])
          hit = 1'b0;
      end
      if (hit) kw_kind = KW_CODE[k];
    end
  end

  always_comb begin
    e1_v = 1'b0; e1_k = TK_ID;
    e2_v = 1'b0; e2_k = TK_ID;
    done = 1'b0; app = 1'b0; app_pos = len; bump = 1'b0;
    mode_next = mode;
    if (end_of_text) begin
      unique case (mode) inside
        M_IDENT:               begin e1_v = 1'b1; e1_k = kw_kind;       end
        M_NUMBER:              begin e1_v = 1'b1; e1_k = TK_INTLITERAL; end
        M_SLASH:               begin e1_v = 1'b1; e1_k = TK_DIVOP;      end
        M_LT:                  begin e1_v = 1'b1; e1_k = TK_LESS;       end
        M_GT:                  begin e1_v = 1'b1; e1_k = TK_GREATER;    end
        M_EQ, M_BANG, M_COLON: begin e1_v = 1'b1; e1_k = TK_ERROR;      end
        default: ;
      endcase
      e2_v = 1'b1; e2_k = TK_SCANEOF;
      mode_next = M_IDLE;
      done = 1'b1;
    end else begin
      unique case (mode) inside
        M_IDENT: begin
          if (is_alpha || is_digit || c == CH_UNDERSCORE) begin
            app = 1'b1; done = 1'b1;
          end else begin
            e1_v = 1'b1; e1_k = kw_kind;
          end
        end
        M_NUMBER: begin
          if (is_digit) done = 1'b1;
          else begin e1_v = 1'b1; e1_k = TK_INTLITERAL; end
        end
        M_SLASH: begin
          if (c == "/") begin mode_next = M_COMMENT; done = 1'b1; end
          else begin e1_v = 1'b1; e1_k = TK_DIVOP; end
        end
        M_COMMENT: begin
          if (c == CH_NL) begin bump = 1'b1; mode_next = M_IDLE; end
          done = 1'b1;
        end
        M_EQ, M_BANG, M_COLON, M_LT, M_GT: begin
          e1_v = 1'b1;
          if (c == "=") begin
            done = 1'b1; mode_next = M_IDLE;
            unique case (mode)
              M_EQ:    e1_k = TK_EQUALS;
              M_BANG:  e1_k = TK_NOTEQ;
              M_COLON: e1_k = TK_ASSIGNOP;
              M_LT:    e1_k = TK_LESSEQ;
              default: e1_k = TK_GREATEQ;
            endcase
          end else begin
            unique case (mode)
              M_LT:    e1_k = TK_LESS;
              M_GT:    e1_k = TK_GREATER;
              default: e1_k = TK_ERROR;
            endcase
          end
        end
        default: ;
      endcase

      // byte not consumed above: handle it from idle
      if (!done) begin
        mode_next = M_IDLE;
        if (is_space) begin
          bump = (c == CH_NL);
        end else if (is_alpha) begin
          app = 1'b1; app_pos = '0; mode_next = M_IDENT;
        end else if (is_digit) begin
          mode_next = M_NUMBER;
        end else begin
          e2_v = 1'b1;
          case (c)
            "(":     e2_k = TK_LPAREN;
            ")":     e2_k = TK_RPAREN;
            "{":     e2_k = TK_LCURL;
            "}":     e2_k = TK_RCURL;
            ",":     e2_k = TK_COMMA;
            ";":     e2_k = TK_SEMICOLON;
            "+":     e2_k = TK_PLUSOP;
            "-":     e2_k = TK_MINUSOP;
            "*":     e2_k = TK_MULTOP;
            "/":     begin e2_v = 1'b0; mode_next = M_SLASH; end
            "=":     begin e2_v = 1'b0; mode_next = M_EQ;    end
            "!":     begin e2_v = 1'b0; mode_next = M_BANG;  end
            "<":     begin e2_v = 1'b0; mode_next = M_LT;    end
            ">":     begin e2_v = 1'b0; mode_next = M_GT;    end
            ":":     begin e2_v = 1'b0; mode_next = M_COLON; end
            default: e2_k = TK_ERROR;
          endcase
        end
      end
    end

    // length saturates one past the window
    len_next = len;
    if (end_of_text) len_next = '0;
    else if (app) begin
      if (app_pos < LEN_W'(KEYWORD_WINDOW + 1)) len_next = app_pos + 1'b1;
      else len_next = app_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      len        <= '0;
      line_count <= LINE_COUNT_BITS'(1);
    end else if (acc) begin
      mode <= mode_next;
      len  <= len_next;
      if (bump && line_count != '1) line_count <= line_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < KEYWORD_WINDOW; i++) begin
      if (acc && app && app_pos == LEN_W'(i)) chars[i] <= c;
    end
  end

  // all results of one byte carry the line before any newline it holds
  assign q_push       = acc && (e1_v || e2_v);
  assign q_data.two   = e1_v && e2_v;
  assign q_data.kind0 = e1_v ? e1_k : e2_k;
  assign q_data.kind1 = e2_k;
  assign q_data.line  = LINE_NUM_W'(line_count);

endmodule

/* hw/rtl/stt_queue.sv */
// Short FIFO of result pairs between the scanner and the output stage.
// Uses stt_pkg.
module stt_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  stt_pkg::result_pair_t wdata,
  output logic                  full,
  input  logic                  pop,
  output stt_pkg::result_pair_t rdata,
  output logic                  avail
);
  import stt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_pair_t     slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = count == CNT_W'(QUEUE_DEPTH);
  assign avail   = count != '0;
  assign do_push = push && !full;
  assign do_pop  = pop && avail;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wdata;
  end

endmodule

/* hw/rtl/stt_back.sv */
// Output stage: holds one result pair and hands out its items one per pop.
// Uses stt_pkg.
module stt_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_avail,
  input  stt_pkg::result_pair_t         q_data,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [stt_pkg::TOKEN_W-1:0]   token_kind,
  output logic [stt_pkg::LINE_NUM_W-1:0] line_number,
  output logic                          last_of_run
);
  import stt_pkg::*;

  result_pair_t cur;
  logic         valid, phase;
  logic         taken, finishing;

  assign finishing = phase || !cur.two;
  assign taken     = pop && valid;
  assign q_pop     = q_avail && (!valid || (taken && finishing));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= 1'b0;
    end else if (taken && !finishing) begin
      phase <= 1'b1;
    end else if (q_pop) begin
      valid <= 1'b1;
      phase <= 1'b0;
    end else if (taken) begin
      valid <= 1'b0;
      phase <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  assign empty       = !valid;
  assign token_kind  = phase ? cur.kind1 : cur.kind0;
  assign line_number = cur.line;
  assign last_of_run = finishing;

endmodule

/* hw/rtl/source_text_tokenizer.sv */
// Top level of the byte-serial source text tokenizer.
// Depends on stt_pkg, stt_front, stt_queue, stt_back and the defines header.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------
//   input    | push / full        | char_byte[7:0], end_of_text
//   result   | empty / pop        | token_kind[4:0], line_number[19:0],
//            |                    | last_of_run
//
// One byte is taken every cycle while full is low; the scanner resolves it
// in that cycle and queues its one or two results, if any, as one entry.
// A result passes through the queue and then the output stage register;
// the output stage gives one item per cycle while pop is high, so a byte
// that yields two items holds it for both, absorbed by the four-entry queue.
// full rises only when that queue is full; reset (rst, synchronous) returns
// the scanner to idle between tokens with line 1 and empties the queue.
module source_text_tokenizer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [stt_pkg::CHAR_W-1:0]     char_byte,
  input  logic                           end_of_text,
  output logic                           empty,
  input  logic                           pop,
  output logic [stt_pkg::TOKEN_W-1:0]    token_kind,
  output logic [stt_pkg::LINE_NUM_W-1:0] line_number,
  output logic                           last_of_run
);
  import stt_pkg::*;

  `include "source_text_tokenizer_defines.svh"

  // scanner -> queue
  logic         fq_push;
  result_pair_t fq_data;
  logic         q_full;

  // queue -> output stage
  logic         q_pop, q_avail;
  result_pair_t q_head;

  stt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .char_byte   (char_byte),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .q_push      (fq_push),
    .q_data      (fq_data)
  );

  stt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_data),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .avail (q_avail)
  );

  stt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_avail     (q_avail),
    .q_data      (q_head),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .token_kind  (token_kind),
    .line_number (line_number),
    .last_of_run (last_of_run)
  );

  // the scanner stalls only on a full queue
  assign full = q_full;

  // end of text always closes the run of its item
  `STT_ASSERT_NOW(a_eof_is_last, !empty && token_kind == TK_SCANEOF, last_of_run, "SCANEOF not last of run")
  // line numbering starts at one and saturates, so never reads zero
  `STT_ASSERT_NOW(a_line_nonzero, !empty, line_number != '0, "line number zero")
  // the second item of a pair follows at once
  `STT_ASSERT_NEXT(a_pair_follows, pop && !empty && !last_of_run, !empty, "second item lost")

endmodule
